[hdl/sorted_priority_queue_aging_assert.svh]
// Assertion macros used by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_AGING_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_AGING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spqa check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spqa check failed");

`endif

[hdl/spqa_pkg.sv]
package spqa_pkg;

    // Default build of the queue
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF    = 16;

    // Fixed word field widths
    localparam int CMD_W       = 2;
    localparam int PID_FIELD_W = 16;
    localparam int PRIO_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_MAX_PRIO = 1'b0;
    localparam logic [PRIO_W-1:0] MAX_PRIO_RESET = 8'd200;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_AGE    = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

[hdl/spqa_if.sv]
// Command channel: one word per scheduler command.
interface spqa_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [spqa_pkg::CMD_W-1:0]       cmd;
    logic [spqa_pkg::PID_FIELD_W-1:0] in_pid;
    logic [spqa_pkg::PRIO_W-1:0]      in_priority;

    modport source (output valid, cmd, in_pid, in_priority, input ready);
    modport sink   (input valid, cmd, in_pid, in_priority, output ready);
endinterface

// Response channel: one word per command.
interface spqa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [spqa_pkg::PID_FIELD_W-1:0] out_pid;
    logic [spqa_pkg::PRIO_W-1:0]      out_priority;
    logic                             took_item;
    logic [spqa_pkg::STATUS_W-1:0]    status;
    logic [spqa_pkg::COUNT_OUT_W-1:0] queue_count;
    logic                             queue_empty;

    modport source (output valid, out_pid, out_priority, took_item, status, queue_count,
                    queue_empty, input ready);
    modport sink   (input valid, out_pid, out_priority, took_item, status, queue_count,
                    queue_empty, output ready);
endinterface

[hdl/sorted_priority_queue_aging.sv]
// A command walks the entry memory one read/write pair per entry, plus one head write when
// an insert lands at the head; a no-op, rejected insert or empty pop walks none.
// One command at a time: the next word is taken the cycle after the response register
// is loaded.
// Reset (synchronous, active low) empties the queue and sets max_priority to 200;
// entry memory contents are not cleared.
module sorted_priority_queue_aging #(
    parameter int QUEUE_DEPTH = spqa_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = spqa_pkg::PID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    spqa_cmd_if.sink                    i_cmd,
    spqa_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spqa_pkg::APB_AW-1:0] paddr,
    input  logic [spqa_pkg::APB_DW-1:0] pwdata,
    output logic [spqa_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int PrioW   = spqa_pkg::PRIO_W;
    localparam int PidFw   = spqa_pkg::PID_FIELD_W;
    localparam int CntOutW = spqa_pkg::COUNT_OUT_W;
    localparam int ApbDw   = spqa_pkg::APB_DW;
    localparam int EntW    = PID_BITS + PrioW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_WR   = 5'b00100,
        S_HEAD = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                      r_state, n_state;
    logic [spqa_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [PID_BITS-1:0]         r_pid, n_pid;
    logic [PrioW-1:0]            r_pri, n_pri;
    logic [AW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_count, n_count;
    logic [PrioW-1:0]            r_maxp;
    logic [PidFw-1:0]            r_res_pid, n_res_pid;
    logic [PrioW-1:0]            r_res_pri, n_res_pri;
    logic                        r_took, n_took;
    spqa_pkg::t_status           r_status, n_status;
    logic                        r_out_valid, n_out_valid;
    logic [PidFw-1:0]            r_out_pid, n_out_pid;
    logic [PrioW-1:0]            r_out_pri, n_out_pri;
    logic                        r_out_took, n_out_took;
    spqa_pkg::t_status           r_out_status, n_out_status;
    logic [CntOutW-1:0]          r_out_count, n_out_count;
    logic                        r_out_empty, n_out_empty;

    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [EntW-1:0]             w_wdata;
    logic [EntW-1:0]             w_rdata;
    logic [PID_BITS-1:0]         w_rd_pid;
    logic [PrioW-1:0]            w_rd_pri;
    logic [PrioW-1:0]            w_aged_pri;
    logic [EntW-1:0]             w_new;
    logic [CW-1:0]               w_count_m1;
    logic [AW-1:0]               w_last;
    logic                        w_cfg_wr;

    // Entry memory, packed as {pid, priority}
    spqa_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EntW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd_pid   = w_rdata[EntW-1:PrioW];
    assign w_rd_pri   = w_rdata[PrioW-1:0];
    assign w_aged_pri = (w_rd_pri < r_maxp) ? w_rd_pri + PrioW'(1) : w_rd_pri;
    assign w_new      = {r_pid, r_pri};
    assign w_count_m1 = r_count - CW'(1);
    assign w_last     = w_count_m1[AW-1:0];

    // Configuration register
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2:2] == spqa_pkg::REG_MAX_PRIO);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2:2] == spqa_pkg::REG_MAX_PRIO) ? ApbDw'(r_maxp) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxp <= spqa_pkg::MAX_PRIO_RESET;
        end else if (w_cfg_wr) begin
            r_maxp <= pwdata[PrioW-1:0];
        end
    end

    // Command sequencer: walk the memory one entry per read/write pair.
    // Each write lands before the next read of any entry, so no forwarding is needed.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_pid        = r_pid;
        n_pri        = r_pri;
        n_idx        = r_idx;
        n_count      = r_count;
        n_res_pid    = r_res_pid;
        n_res_pri    = r_res_pri;
        n_took       = r_took;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_pid    = r_out_pid;
        n_out_pri    = r_out_pri;
        n_out_took   = r_out_took;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = w_rdata;

        case (r_state)
            S_IDLE: begin
                // Take a command word and choose the walk
                if (i_cmd.valid) begin
                    n_cmd     = i_cmd.cmd;
                    n_pid     = PID_BITS'(i_cmd.in_pid);
                    n_pri     = i_cmd.in_priority;
                    n_res_pid = '0;
                    n_res_pri = '0;
                    n_took    = 1'b0;
                    n_status  = spqa_pkg::ST_OK;
                    n_state   = S_DONE;
                    case (i_cmd.cmd)
                        spqa_pkg::CMD_INSERT: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = spqa_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                n_state = S_HEAD;
                            end else begin
                                n_idx   = w_last;
                                n_state = S_RD;
                            end
                        end
                        spqa_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = spqa_pkg::ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_RD;
                            end
                        end
                        spqa_pkg::CMD_AGE: begin
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_RD: begin
                n_state = S_WR;
            end

            S_WR: begin
                case (r_cmd)
                    spqa_pkg::CMD_INSERT: begin
                        // Shift one entry down, or drop the new one in behind it
                        w_we    = 1'b1;
                        w_waddr = r_idx + AW'(1);
                        if (w_rd_pri >= r_pri) begin
                            w_wdata = w_new;
                            n_count = r_count + CW'(1);
                            n_state = S_DONE;
                        end else if (r_idx == '0) begin
                            n_state = S_HEAD;
                        end else begin
                            n_idx   = r_idx - AW'(1);
                            n_state = S_RD;
                        end
                    end
                    spqa_pkg::CMD_POP: begin
                        // Capture the head, move the rest up by one
                        if (r_idx == '0) begin
                            n_res_pid = PidFw'(w_rd_pid);
                            n_res_pri = w_rd_pri;
                            n_took    = 1'b1;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_idx - AW'(1);
                        end
                        if (r_idx == w_last) begin
                            n_count = w_count_m1;
                            n_state = S_DONE;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = S_RD;
                        end
                    end
                    spqa_pkg::CMD_AGE: begin
                        // Raise the priority in place, saturating at the ceiling
                        w_we    = 1'b1;
                        w_wdata = {w_rd_pid, w_aged_pri};
                        if (r_idx == w_last) begin
                            n_state = S_DONE;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_HEAD: begin
                // New entry goes to the head
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = w_new;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end

            S_DONE: begin
                // Load the response word once the register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_pid    = r_res_pid;
                    n_out_pri    = r_res_pri;
                    n_out_took   = r_took;
                    n_out_status = r_status;
                    n_out_count  = CntOutW'(r_count);
                    n_out_empty  = (r_count == '0);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_pid        <= n_pid;
        r_pri        <= n_pri;
        r_idx        <= n_idx;
        r_res_pid    <= n_res_pid;
        r_res_pri    <= n_res_pri;
        r_took       <= n_took;
        r_status     <= n_status;
        r_out_pid    <= n_out_pid;
        r_out_pri    <= n_out_pri;
        r_out_took   <= n_out_took;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_empty  <= n_out_empty;
    end

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.out_pid      = r_out_pid;
    assign o_rsp.out_priority = r_out_pri;
    assign o_rsp.took_item    = r_out_took;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.queue_count  = r_out_count;
    assign o_rsp.queue_empty  = r_out_empty;

endmodule

[hdl/spqa_mem.sv]
// Entry store: one write port, one read port with registered read data.
module spqa_mem #(
    parameter int DEPTH = spqa_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = spqa_pkg::PID_BITS_DEF + spqa_pkg::PRIO_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/spqa_chk.sv]
`include "sorted_priority_queue_aging_assert.svh"

// Port-level checks on the response channel.
module spqa_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [spqa_pkg::PID_FIELD_W-1:0] i_out_pid,
    input  logic [spqa_pkg::PRIO_W-1:0]      i_out_priority,
    input  logic                             i_took,
    input  logic [spqa_pkg::STATUS_W-1:0]    i_status,
    input  logic [spqa_pkg::COUNT_OUT_W-1:0] i_count,
    input  logic                             i_empty
);

    // Held response word must not change
    `SPQA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_pid, i_out_priority, i_took, i_status, i_count, i_empty}))

    // Empty flag agrees with the reported count
    `SPQA_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, i_out_valid, i_empty == (i_count == '0))

    // No entry taken means zero identifier and priority
    `SPQA_ASSERT_NOW(a_no_take_zero, i_clk, i_rst_n, i_out_valid && !i_took, (i_out_pid == '0) && (i_out_priority == '0))

    // Pop on empty returns nothing and leaves the queue empty
    `SPQA_ASSERT_NOW(a_pop_empty, i_clk, i_rst_n, i_out_valid && (i_status == spqa_pkg::ST_EMPTY), i_empty && !i_took)

endmodule

bind sorted_priority_queue_aging spqa_chk u_spqa_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_out_pid      (o_rsp.out_pid),
    .i_out_priority (o_rsp.out_priority),
    .i_took         (o_rsp.took_item),
    .i_status       (o_rsp.status),
    .i_count        (o_rsp.queue_count),
    .i_empty        (o_rsp.queue_empty)
);

[dv/tb_sorted_priority_queue_aging.sv]
`timescale 1ns / 1ps

module tb_sorted_priority_queue_aging;
    import spqa_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    // Command code 3 has no operation behind it
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam logic [APB_AW-1:0] MAX_PRIO_ADDR = APB_AW'(4 * REG_MAX_PRIO);
    // Longest walk of the entry memory, plus a little margin
    localparam int WALK_SLACK = 2 * DEPTH + 6;
    localparam int IDLE_PCT = 32;

    typedef struct packed {
        logic [PID_FIELD_W-1:0] pid;
        logic [PRIO_W-1:0]      prio;
        logic                   took;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] count;
        logic                   empty;
    } reply_t;

    // Shadow of the ready queue: predicts one reply word per command word
    class ready_queue_shadow;
        logic [PID_FIELD_W-1:0] slot_pid [DEPTH];
        logic [PRIO_W-1:0]      slot_prio [DEPTH];
        int unsigned            held;
        logic [PRIO_W-1:0]      prio_ceiling;
        reply_t                 awaited_replies [$];
        int unsigned            mismatches;

        function new();
            held = 0;
            prio_ceiling = MAX_PRIO_RESET;
            mismatches = 0;
        endfunction

        function void set_ceiling(logic [PRIO_W-1:0] value);
            prio_ceiling = value;
        endfunction

        function int unsigned awaited();
            return awaited_replies.size();
        endfunction

        function void note_command(logic [CMD_W-1:0] op, logic [PID_FIELD_W-1:0] pid,
                                   logic [PRIO_W-1:0] prio);
            reply_t      want;
            int unsigned pos;
            int unsigned i;
            want = '0;
            want.status = ST_OK;
            case (op)
                CMD_INSERT: begin
                    if (held >= DEPTH) begin
                        want.status = ST_FULL;
                    end else begin
                        // Place behind every entry of equal or higher priority
                        pos = 0;
                        while (pos < held && slot_prio[pos] >= prio)
                            pos++;
                        for (i = held; i > pos; i--) begin
                            slot_pid[i] = slot_pid[i-1];
                            slot_prio[i] = slot_prio[i-1];
                        end
                        slot_pid[pos] = pid;
                        slot_prio[pos] = prio;
                        held++;
                    end
                end
                CMD_POP: begin
                    if (held == 0) begin
                        want.status = ST_EMPTY;
                    end else begin
                        want.pid = slot_pid[0];
                        want.prio = slot_prio[0];
                        want.took = 1'b1;
                        for (i = 1; i < held; i++) begin
                            slot_pid[i-1] = slot_pid[i];
                            slot_prio[i-1] = slot_prio[i];
                        end
                        held--;
                    end
                end
                CMD_AGE: begin
                    // Raise each entry by one, never past the ceiling
                    for (i = 0; i < held; i++)
                        if (slot_prio[i] < prio_ceiling)
                            slot_prio[i] = slot_prio[i] + 8'd1;
                end
                default: ;
            endcase
            want.count = COUNT_OUT_W'(held);
            want.empty = (held == 0);
            awaited_replies.push_back(want);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: reply word with none awaited: pid %h pri %0d took %0b",
                             $time, got.pid, got.prio, got.took);
                return;
            end
            want = awaited_replies.pop_front();
            if (got.pid !== want.pid || got.prio !== want.prio || got.took !== want.took ||
                got.status !== want.status || got.count !== want.count ||
                got.empty !== want.empty) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: reply mismatch", $time);
                    $display("  want pid %h pri %0d took %0b status %0d count %0d empty %0b",
                             want.pid, want.prio, want.took, want.status, want.count,
                             want.empty);
                    $display("  got  pid %h pri %0d took %0b status %0d count %0d empty %0b",
                             got.pid, got.prio, got.took, got.status, got.count, got.empty);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;
    bit steady = 1'b0;

    ready_queue_shadow shadow = new();

    spqa_cmd_if cmd_if ();
    spqa_rsp_if rsp_if ();

    sorted_priority_queue_aging dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the reply side at random, except during the steady stretch
    always @(negedge i_clk) begin
        rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Check every accepted reply word
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            shadow.check_reply('{pid: rsp_if.out_pid, prio: rsp_if.out_priority,
                                 took: rsp_if.took_item, status: rsp_if.status,
                                 count: rsp_if.queue_count, empty: rsp_if.queue_empty});
    end

    // Offer one command word, with an occasional gap in front of it
    task automatic push_command(input logic [CMD_W-1:0] op, input logic [PID_FIELD_W-1:0] pid,
                                input logic [PRIO_W-1:0] prio);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_if.valid <= 1'b1;
        cmd_if.cmd <= op;
        cmd_if.in_pid <= pid;
        cmd_if.in_priority <= prio;
        do @(posedge i_clk); while (!cmd_if.ready);
        shadow.note_command(op, pid, prio);
    endtask

    // Hold the command side until every awaited reply has arrived
    task automatic drain_replies();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (shadow.awaited() != 0)
            @(posedge i_clk);
    endtask

    // Write the aging ceiling once the queue logic has gone quiet
    task automatic write_ceiling(input logic [PRIO_W-1:0] value);
        drain_replies();
        repeat (WALK_SLACK) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_PRIO_ADDR;
        pwdata <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow.set_ceiling(value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // One random command word, mix of operations set by the caller
    task automatic random_command(input int unsigned insert_pct, input int unsigned pop_pct);
        int unsigned roll;
        logic [CMD_W-1:0] op;
        logic [PRIO_W-1:0] prio;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            op = CMD_INSERT;
        else if (roll < insert_pct + pop_pct)
            op = CMD_POP;
        else if (roll < 97)
            op = CMD_AGE;
        else
            op = CMD_NOP;
        // Narrow band gives ties, the rest spread wide or sit near the ceiling
        case ($urandom_range(0, 3))
            0: prio = 8'($urandom_range(100, 103));
            1: prio = 8'(shadow.prio_ceiling + $urandom_range(0, 2) - 1);
            default: prio = 8'($urandom_range(0, 255));
        endcase
        push_command(op, 16'($urandom_range(0, 65535)), prio);
    endtask

    initial begin
        logic [PRIO_W-1:0] ceilings [5];
        int unsigned ph;
        int unsigned n;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.cmd = CMD_NOP;
        cmd_if.in_pid = '0;
        cmd_if.in_priority = '0;
        rsp_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue, no-op, extremes, ties, aging at the ceiling
        push_command(CMD_POP, 16'h0000, 8'd0);
        push_command(CMD_AGE, 16'h0000, 8'd0);
        push_command(CMD_NOP, 16'hFFFF, 8'd255);
        push_command(CMD_INSERT, 16'hFFFF, 8'd255);
        push_command(CMD_INSERT, 16'h0000, 8'd0);
        push_command(CMD_INSERT, 16'h1234, 8'd100);
        push_command(CMD_INSERT, 16'h5678, 8'd100);
        push_command(CMD_AGE, 16'h0000, 8'd0);
        push_command(CMD_POP, 16'h0000, 8'd0);
        push_command(CMD_INSERT, 16'h00AA, 8'd101);
        // Fill to the brim, then try one more and age a full queue
        for (n = 0; n < 12; n++)
            push_command(CMD_INSERT, 16'h8000 | 16'(n), 8'(n * 23));
        push_command(CMD_INSERT, 16'hBEEF, 8'd255);
        push_command(CMD_AGE, 16'h0000, 8'd0);
        push_command(CMD_POP, 16'h0000, 8'd0);

        // Random phases, each under its own ceiling
        ceilings = '{8'd255, 8'd0, 8'd1, 8'($urandom_range(2, 254)), MAX_PRIO_RESET};
        for (ph = 0; ph < 5; ph++) begin
            write_ceiling(ceilings[ph]);
            steady = (ph == 2);
            for (n = 0; n < 80; n++) begin
                if (ph == 1 && n == 40)
                    drain_replies();
                if (n < 30)
                    random_command(65, 20);
                else if (n < 60)
                    random_command(25, 60);
                else
                    random_command(40, 40);
            end
            steady = 1'b0;
        end

        drain_replies();
        repeat (WALK_SLACK) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.awaited() == 0) begin
            $display("tb_sorted_priority_queue_aging: done, clean");
        end else begin
            $display("tb_sorted_priority_queue_aging: done, errors");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #2_000_000;
        $display("tb_sorted_priority_queue_aging: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/spqa_pkg.sv
hdl/spqa_if.sv
hdl/spqa_mem.sv
hdl/sorted_priority_queue_aging.sv
hdl/spqa_chk.sv
dv/tb_sorted_priority_queue_aging.sv
